// ===== design/cprx_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 step for the COBS frame receiver.
package cprx_pkg;

	localparam int unsigned HDR_LEN = 16;
	localparam int unsigned CRC_LEN = 4;
	localparam int unsigned RAW_W   = 17;

	localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
	localparam logic [7:0]  FULL_CODE = 8'hFF;

	// Verdict codes
	localparam logic [3:0] ST_OK           = 4'd0;
	localparam logic [3:0] ST_EMPTY        = 4'd1;
	localparam logic [3:0] ST_STUFFING     = 4'd2;
	localparam logic [3:0] ST_SHORT        = 4'd3;
	localparam logic [3:0] ST_MAGIC        = 4'd4;
	localparam logic [3:0] ST_VERSION      = 4'd5;
	localparam logic [3:0] ST_LEN_FIELD    = 4'd6;
	localparam logic [3:0] ST_LEN_MISMATCH = 4'd7;
	localparam logic [3:0] ST_CRC          = 4'd8;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAGIC       = 2'd0;
	localparam logic [1:0] CFG_VERSION     = 2'd1;
	localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

	typedef logic [RAW_W-1:0] raw_t;

	typedef struct packed {
		logic [15:0] frame_magic;
		logic [7:0]  proto_ver;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [3:0]  status;
		logic [7:0]  command;
		logic [31:0] image_id;
		logic [31:0] image_offset;
		logic [15:0] sequence_res;
		logic [15:0] body_len;
		logic        last;
	} result_t;

	// One byte through the reflected CRC-32, eight bit steps unrolled.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/cprx_core.sv =====
// Frame state: COBS unstuffing, header capture, CRC and the end-of-frame verdict.
module cprx_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	input  cprx_pkg::cfg_t    cfg,
	output logic              res_valid,
	output cprx_pkg::result_t res
);
	import cprx_pkg::*;

	raw_t        raw_q, raw_n;
	logic [7:0]  group_left_q, group_left_n;
	logic        group_full_q, group_full_n;
	logic        zero_pending_q, zero_pending_n;
	logic        stuffing_bad_q, stuffing_bad_n;
	logic [31:0] crc_q, crc_n;
	logic [31:0] rcv_crc_q, rcv_crc_n;
	logic [7:0]  hdr_q [HDR_LEN];

	logic        hdr_we;
	logic        dec_en;
	logic [7:0]  dec_b;
	logic [3:0]  status_v;
	logic [15:0] hdr_len;
	raw_t        limit;
	raw_t        payload_end;
	raw_t        frame_len;

	assign hdr_len     = {hdr_q[15], hdr_q[14]};
	assign limit       = raw_t'(HDR_LEN + CRC_LEN) + {1'b0, cfg.max_payload};
	assign payload_end = raw_t'(HDR_LEN) + {1'b0, hdr_len};
	assign frame_len   = raw_t'(HDR_LEN + CRC_LEN) + {1'b0, hdr_len};

	always_comb begin
		if (raw_q == '0 && group_left_q == 8'd0 && !zero_pending_q && !stuffing_bad_q) begin
			status_v = ST_EMPTY;
		end else if (stuffing_bad_q || group_left_q != 8'd0) begin
			status_v = ST_STUFFING;
		end else if (raw_q < raw_t'(HDR_LEN + CRC_LEN)) begin
			status_v = ST_SHORT;
		end else if ({hdr_q[1], hdr_q[0]} != cfg.frame_magic) begin
			status_v = ST_MAGIC;
		end else if (hdr_q[2] != cfg.proto_ver) begin
			status_v = ST_VERSION;
		end else if (hdr_len > cfg.max_payload) begin
			status_v = ST_LEN_FIELD;
		end else if (raw_q != frame_len) begin
			status_v = ST_LEN_MISMATCH;
		end else if ((crc_q ^ CRC_ONES) != rcv_crc_q) begin
			status_v = ST_CRC;
		end else begin
			status_v = ST_OK;
		end
	end

	always_comb begin
		raw_n          = raw_q;
		group_left_n   = group_left_q;
		group_full_n   = group_full_q;
		zero_pending_n = zero_pending_q;
		stuffing_bad_n = stuffing_bad_q;
		crc_n          = crc_q;
		rcv_crc_n      = rcv_crc_q;
		hdr_we         = 1'b0;
		dec_en         = 1'b0;
		dec_b          = rx_byte;
		res_valid      = 1'b0;
		res            = '0;
		if (take) begin
			if (rx_byte == 8'd0) begin
				res_valid = 1'b1;
				res.kind  = 1'b1;
				res.last  = 1'b1;
				res.status = status_v;
				if (raw_q >= raw_t'(HDR_LEN)) begin
					res.command      = hdr_q[3];
					res.image_id     = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
					res.image_offset = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
					res.sequence_res = {hdr_q[13], hdr_q[12]};
					res.body_len     = hdr_len;
				end
				raw_n          = '0;
				group_left_n   = 8'd0;
				group_full_n   = 1'b0;
				zero_pending_n = 1'b0;
				stuffing_bad_n = 1'b0;
				crc_n          = CRC_ONES;
				rcv_crc_n      = 32'd0;
			end else begin
				if (group_left_q == 8'd0) begin
					// Code byte: the zero owed by a short group is only now decoded.
					dec_en         = zero_pending_q;
					dec_b          = 8'd0;
					group_left_n   = rx_byte - 8'd1;
					group_full_n   = (rx_byte == FULL_CODE);
					zero_pending_n = (rx_byte == 8'd1);
				end else begin
					dec_en       = 1'b1;
					group_left_n = group_left_q - 8'd1;
					if (group_left_q == 8'd1) begin
						zero_pending_n = !group_full_q;
					end
				end
				if (dec_en && !stuffing_bad_q) begin
					if (raw_q >= limit) begin
						stuffing_bad_n = 1'b1;
					end else begin
						if (raw_q < raw_t'(HDR_LEN)) begin
							hdr_we = 1'b1;
							crc_n  = crc_byte(crc_q, dec_b);
						end else if (raw_q < payload_end) begin
							crc_n          = crc_byte(crc_q, dec_b);
							res_valid      = 1'b1;
							res.data_byte  = dec_b;
						end else begin
							rcv_crc_n = {dec_b, rcv_crc_q[31:8]};
						end
						raw_n = raw_q + raw_t'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q          <= '0;
			group_left_q   <= 8'd0;
			group_full_q   <= 1'b0;
			zero_pending_q <= 1'b0;
			stuffing_bad_q <= 1'b0;
			crc_q          <= CRC_ONES;
			rcv_crc_q      <= 32'd0;
		end else begin
			raw_q          <= raw_n;
			group_left_q   <= group_left_n;
			group_full_q   <= group_full_n;
			zero_pending_q <= zero_pending_n;
			stuffing_bad_q <= stuffing_bad_n;
			crc_q          <= crc_n;
			rcv_crc_q      <= rcv_crc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_q[raw_q[3:0]] <= dec_b;
		end
	end

endmodule

// ===== design/cobs_packet_frame_receiver.sv =====
// Top level of the COBS packet frame receiver: handshakes, configuration and result register.
//
// Takes one stuffed link byte per clock and gives at most one result per byte: a decoded
// payload byte (kind 0) or, on each zero delimiter, a verdict (kind 1, last 1) carrying the
// header fields and a status; a nonzero status means the payload bytes already sent must be
// dropped. Each byte goes through the unstuffing, CRC-32 and verdict logic combinationally
// into one result register, so a request is taken every cycle while that register is empty
// or being drained; the result appears in the cycle after its byte is accepted. in_stall rises
// only while a held result is stalled at the output. Configuration writes are always ready
// and act from the next cycle.
module cobs_packet_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic [3:0]  status,
	output logic [7:0]  command,
	output logic [31:0] image_id,
	output logic [31:0] image_offset,
	output logic [15:0] sequence_res,
	output logic [15:0] body_len,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import cprx_pkg::*;

	cfg_t    cfg_q;
	result_t out_q;
	logic    out_valid_q;
	logic    in_take;
	logic    res_valid;
	result_t res;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q && out_stall;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_magic <= 16'd0;
			cfg_q.proto_ver   <= 8'd0;
			cfg_q.max_payload <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAGIC:       cfg_q.frame_magic <= cfg_data;
				CFG_VERSION:     cfg_q.proto_ver   <= cfg_data[7:0];
				CFG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data;
				default: ;
			endcase
		end
	end

	cprx_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (in_take),
		.rx_byte   (rx_byte),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// The result register loads only when it is empty or being taken, so a stalled result holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_q.kind;
	assign data_byte    = out_q.data_byte;
	assign status       = out_q.status;
	assign command      = out_q.command;
	assign image_id     = out_q.image_id;
	assign image_offset = out_q.image_offset;
	assign sequence_res = out_q.sequence_res;
	assign body_len     = out_q.body_len;
	assign last         = out_q.last;

`ifndef SYNTH
	a_delim_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && rx_byte == 8'd0) |=> (out_valid && kind && last))
		else $error("delimiter did not produce a verdict");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty result register");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (status == ST_OK && !last))
		else $error("payload byte carries verdict fields");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> (last && data_byte == 8'd0 && status <= ST_CRC))
		else $error("malformed verdict");
`endif

endmodule
